@@ rtl/iirl_pkg.sv @@
`default_nettype none

package iirl_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;
    localparam int ST_W  = 2;

    localparam int Q_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_WRITE
    } back_op_t;

    typedef struct packed {
        back_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
        status_t           status;
    } queue_word_t;

endpackage

`default_nettype wire

@@ rtl/iirl_if.sv @@
`default_nettype none

interface iirl_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [iirl_pkg::CMD_W-1:0] command;
    logic [iirl_pkg::POS_W-1:0] position;
    logic [iirl_pkg::VAL_W-1:0] item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface iirl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [iirl_pkg::VAL_W-1:0] old_value;
    logic [iirl_pkg::CNT_W-1:0] entry_count;
    logic [iirl_pkg::ST_W-1:0]  status;

    modport source (output valid, old_value, entry_count, status, input ready);
    modport sink   (input valid, old_value, entry_count, status, output ready);
endinterface

`default_nettype wire

@@ rtl/indexed_insert_remove_list.sv @@
// Response path: an accepted command word is written into the queue, then popped
// into the response register, from which the response side takes it.
// Throughput: one command word per cycle while responses are taken; the shift
// row moves all entries at and above a command's position at once.
// A stalled response fills the 2-word queue, then the command side stalls.
// Reset: entry count cleared, queue and response register empty; entry
// contents are undefined until written.
`default_nettype none

module indexed_insert_remove_list #(
    parameter int CAPACITY   = iirl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iirl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iirl_cmd_if.sink   cmd,
    iirl_rsp_if.source rsp
);
    import iirl_pkg::*;

    queue_word_t push_word;
    queue_word_t head_word;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;

    iirl_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_push (q_push),
        .q_data (push_word),
        .q_full (q_full)
    );

    iirl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_word),
        .full  (q_full),
        .valid (q_valid),
        .dout  (head_word),
        .pop   (q_pop)
    );

    iirl_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (head_word),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/iirl_front.sv @@
`default_nettype none

module iirl_front #(
    parameter int CAPACITY = iirl_pkg::CAPACITY_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    iirl_cmd_if.sink                   cmd,
    output logic                       q_push,
    output iirl_pkg::queue_word_t      q_data,
    input  wire logic                  q_full
);
    import iirl_pkg::*;

    localparam int CNT_IW = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_IW > POS_W) ? CNT_IW : POS_W;

    logic [CNT_IW-1:0] cnt_reg;
    logic [CNT_IW-1:0] cnt_next;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              is_full;
    logic              accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;
    assign q_push    = accept;

    always_comb
    begin
        pos_x         = CMP_W'(cmd.position);
        cnt_x         = CMP_W'(cnt_reg);
        is_full       = (cnt_reg == CNT_IW'(CAPACITY));
        cnt_next      = cnt_reg;
        q_data.op     = OP_NONE;
        q_data.status = ST_OK;
        q_data.pos    = cmd.position;
        q_data.value  = cmd.item_value;
        case (cmd_t'(cmd.command))
            CMD_INSERT:
            begin
                if (pos_x > cnt_x)
                    q_data.status = ST_RANGE;
                else if (is_full)
                    q_data.status = ST_FULL;
                else
                begin
                    q_data.op = OP_INSERT;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    q_data.status = ST_RANGE;
                else
                begin
                    q_data.op = OP_REMOVE;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            CMD_GET:
            begin
                if (pos_x >= cnt_x)
                    q_data.status = ST_RANGE;
                else
                    q_data.op = OP_READ;
            end
            CMD_SET:
            begin
                if (pos_x > cnt_x)
                    q_data.status = ST_RANGE;
                else if (pos_x < cnt_x)
                    q_data.op = OP_WRITE;
                else if (is_full)
                    q_data.status = ST_FULL;
                else
                begin
                    q_data.op = OP_INSERT;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                q_data.op = OP_NONE;
            end
        endcase
        q_data.count = CNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_IW'(CAPACITY))
        else $error("entry count above capacity");

    a_reject_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && q_data.status != ST_OK |=> $stable(cnt_reg))
        else $error("rejected word changed the count");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && q_data.op == OP_REMOVE |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("remove did not decrement the count");
`endif

endmodule

`default_nettype wire

@@ rtl/iirl_queue.sv @@
`default_nettype none

module iirl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire iirl_pkg::queue_word_t din,
    output logic                       full,
    output logic                       valid,
    output iirl_pkg::queue_word_t      dout,
    input  wire logic                  pop
);
    import iirl_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int OCC_W = $clog2(Q_DEPTH + 1);

    queue_word_t      slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0] occ_reg;

    assign full  = (occ_reg == OCC_W'(Q_DEPTH));
    assign valid = (occ_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                occ_reg <= occ_reg + 1'b1;
            else if (pop && !push)
                occ_reg <= occ_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/iirl_back.sv @@
`default_nettype none

module iirl_back #(
    parameter int CAPACITY   = iirl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iirl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire iirl_pkg::queue_word_t q_data,
    output logic                       q_pop,
    iirl_rsp_if.source                 rsp
);
    import iirl_pkg::*;

    logic [DATA_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
    logic [DATA_WIDTH-1:0] wr_val;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [VAL_W-1:0]      old_next;

    logic                  rsp_valid_reg;
    logic [VAL_W-1:0]      old_reg;
    logic [CNT_W-1:0]      count_reg;
    status_t               status_reg;

    assign q_pop  = q_valid && (!rsp_valid_reg || rsp.ready);
    assign wr_val = DATA_WIDTH'(q_data.value);

    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == int'(q_data.pos))
                rd_val = cells_reg[i];
        end
    end

    // next row: insert and remove shift the entries at and above the position at once
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            cells_next[i] = cells_reg[i];
        case (q_data.op)
            OP_INSERT:
            begin
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (i > int'(q_data.pos))
                        cells_next[i] = cells_reg[i-1];
                end
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (i == int'(q_data.pos))
                        cells_next[i] = wr_val;
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (i >= int'(q_data.pos))
                        cells_next[i] = cells_reg[i+1];
                end
            end
            OP_WRITE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (i == int'(q_data.pos))
                        cells_next[i] = wr_val;
                end
            end
            default:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    cells_next[i] = cells_reg[i];
            end
        endcase
    end

    always_comb
    begin
        case (q_data.op)
            OP_REMOVE, OP_READ, OP_WRITE: old_next = VAL_W'(rd_val);
            default:                      old_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cells_reg[i] <= cells_next[i];
            old_reg    <= old_next;
            count_reg  <= q_data.count;
            status_reg <= q_data.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (q_pop)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.old_value   = old_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.status      = status_reg;

endmodule

`default_nettype wire
